>>> design/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared constants for the circle span and point generator.
// ----------------------------------------------------------------------------
package csp_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;

   localparam int D_START     = 3;
   localparam int D_STEP_DIAG = 10;
   localparam int D_STEP_AXIS = 6;

   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

   localparam logic MODE_FILL    = 1'b0;
   localparam logic MODE_OUTLINE = 1'b1;

   localparam logic [2:0] FILL_LAST_IDX    = 3'd3;
   localparam logic [2:0] OUTLINE_LAST_IDX = 3'd7;

endpackage

>>> design/csp_if.sv
// ----------------------------------------------------------------------------
// csp_if
// Valid/ready channels for circle requests and span/point responses.
// ----------------------------------------------------------------------------
interface csp_req_if #(
   parameter int CB = 16
);
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic signed [CB-1:0] center_x;
   logic signed [CB-1:0] center_y;
   logic        [CB-2:0] radius;

   modport source (output valid, action, center_x, center_y, radius, input ready);
   modport sink   (input valid, action, center_x, center_y, radius, output ready);
endinterface

interface csp_rsp_if #(
   parameter int CB = 16
);
   logic               valid;
   logic               ready;
   logic signed [CB:0] span_start_x;
   logic signed [CB:0] span_end_x;
   logic signed [CB:0] row_y;
   logic               vertical_piece;
   logic               last;
   logic               circle_done;

   modport source (output valid, span_start_x, span_end_x, row_y, vertical_piece, last,
                   circle_done, input ready);
   modport sink   (input valid, span_start_x, span_end_x, row_y, vertical_piece, last,
                   circle_done, output ready);
endinterface

>>> design/circle_span_and_point_generator_core.sv
// ----------------------------------------------------------------------------
// circle_span_and_point_generator_core
// Midpoint circle generator: fill spans or outline points per octant step.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       beat contents
//  req_chan  in   valid/ready     action, center_x, center_y, radius
//  rsp_chan  out  valid/ready     span_start_x, span_end_x, row_y, flags
//  csr_*     in   write enable    draw_mode
//
//  A start yields no beats; an advance passes the front and the step queue,
//  then the back expands it into 4 (fill) or 8 (outline) beats. Sustained
//  rate is set by the back's single output register. Synchronous reset clears
//  control state (no clearing pass); queue storage and output data are not reset.
//  Requests stall only while the step queue is full; responses hold on stall.
// ----------------------------------------------------------------------------
module circle_span_and_point_generator_core
   import csp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   csp_req_if.sink  req_chan,
   csp_rsp_if.source rsp_chan,
   input  logic     csr_write_en,
   input  logic     csr_write_data
);

   localparam int JOB_BITS = 2 + 4 * COORD_BITS;

   logic                push_valid, push_ready, pop_valid, pop_ready;
   logic [JOB_BITS-1:0] push_data, pop_data;

   csp_front #(
      .COORD_BITS (COORD_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .job_valid      (push_valid),
      .job_ready      (push_ready),
      .job_data       (push_data)
   );

   csp_queue #(
      .WIDTH (JOB_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   csp_back #(
      .COORD_BITS (COORD_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_data  (pop_data),
      .rsp       (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.circle_done) |-> rsp_chan.last)
      else $error("circle_done without last");

   a_point_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.vertical_piece) |->
      (rsp_chan.span_start_x == rsp_chan.span_end_x))
      else $error("vertical point with unequal ends");

   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

   a_back_drains: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && !rsp_chan.valid) |=> rsp_chan.valid)
      else $error("queued step not started");
`endif

endmodule

>>> design/csp_front.sv
// ----------------------------------------------------------------------------
// csp_front
// Accepts requests, holds circle state, runs the decision update per step.
// ----------------------------------------------------------------------------
module csp_front
   import csp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int JOB_BITS   = 2 + 4 * COORD_BITS
) (
   input  logic                clock,
   input  logic                reset,
   csp_req_if.sink             req,
   input  logic                csr_write_en,
   input  logic                csr_write_data,
   output logic                job_valid,
   input  logic                job_ready,
   output logic [JOB_BITS-1:0] job_data
);

   localparam int CB = COORD_BITS;
   localparam int DB = COORD_BITS + 4;

   typedef struct packed {
      logic                 mode;
      logic                 done;
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
   } job_type;

   logic                 mode_ff, mode_in;
   logic                 active_ff, active_in;
   logic signed [CB-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CB-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [DB-1:0] d_ff, d_in;

   logic                 accept;
   logic signed [CB-1:0] x_next, y_next, x_load;
   logic signed [DB-1:0] d_next, diff_ext, y_ext;
   job_type              job;

   assign req.ready = job_ready;
   assign accept    = req.valid && req.ready;
   assign job_valid = accept && (req.action == ACT_ADVANCE) && active_ff;

   assign x_load   = {1'b0, req.radius};
   assign diff_ext = DB'(y_ff) - DB'(x_ff);
   assign y_ext    = DB'(y_ff);
   assign y_next   = y_ff + CB'(1);

   always_comb begin
      if (d_ff > 0) begin
         d_next = d_ff + (diff_ext <<< 2) + DB'(D_STEP_DIAG);
         x_next = x_ff - CB'(1);
      end else begin
         d_next = d_ff + (y_ext <<< 2) + DB'(D_STEP_AXIS);
         x_next = x_ff;
      end
   end

   always_comb begin
      job.mode = mode_ff;
      job.done = x_next < y_next;
      job.cx   = cx_ff;
      job.cy   = cy_ff;
      job.x    = x_ff;
      job.y    = y_ff;
   end
   assign job_data = job;

   always_comb begin
      mode_in   = csr_write_en ? csr_write_data : mode_ff;
      active_in = active_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      if (accept && req.action == ACT_START) begin
         cx_in     = req.center_x;
         cy_in     = req.center_y;
         x_in      = x_load;
         y_in      = '0;
         d_in      = DB'(D_START) - (DB'(x_load) <<< 1);
         active_in = 1'b1;
      end else if (job_valid) begin
         x_in      = x_next;
         y_in      = y_next;
         d_in      = d_next;
         active_in = !job.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FILL;
         active_ff <= 1'b0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         d_ff      <= '0;
      end else begin
         mode_ff   <= mode_in;
         active_ff <= active_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         d_ff      <= d_in;
      end
   end

endmodule

>>> design/csp_queue.sv
// ----------------------------------------------------------------------------
// csp_queue
// Small register queue of step jobs between front and back.
// ----------------------------------------------------------------------------
module csp_queue
   import csp_pkg::*;
#(
   parameter int WIDTH = 2 + 4 * COORD_BITS_DEFAULT,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNB = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AB-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNB-1:0]   count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNB'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AB'(DEPTH - 1)) ? '0 : wr_ptr_ff + AB'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AB'(DEPTH - 1)) ? '0 : rd_ptr_ff + AB'(1);
      end
      count_in = count_ff + CNB'(push) - CNB'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> design/csp_back.sv
// ----------------------------------------------------------------------------
// csp_back
// Expands one step job into four spans or eight points, one beat a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module csp_back
   import csp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int JOB_BITS   = 2 + 4 * COORD_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  logic [JOB_BITS-1:0] job_data,
   csp_rsp_if.source           rsp
);

   localparam int CB = COORD_BITS;
   localparam int WB = COORD_BITS + 2;

   typedef struct packed {
      logic                 mode;
      logic                 done;
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
   } job_type;

   job_type              job;
   logic [2:0]           idx_ff, idx_in, last_idx;
   logic                 load, is_last;
   logic signed [WB-1:0] cx_w, cy_w, a_w, b_w;
   logic signed [WB-1:0] start_w, end_w, row_w;
   logic                 vert;

   logic                 valid_ff, valid_in;
   logic signed [CB:0]   start_ff, end_ff, row_ff;
   logic                 vert_ff, last_ff, done_ff;

   assign job      = job_type'(job_data);
   assign last_idx = (job.mode == MODE_OUTLINE) ? OUTLINE_LAST_IDX : FILL_LAST_IDX;
   assign is_last  = idx_ff == last_idx;
   assign load     = job_valid && (!valid_ff || rsp.ready);
   assign job_ready = load && is_last;

   assign cx_w = WB'(job.cx);
   assign cy_w = WB'(job.cy);

   always_comb begin
      if (job.mode == MODE_OUTLINE) begin
         a_w     = idx_ff[2] ? WB'(job.y) : WB'(job.x);
         b_w     = idx_ff[2] ? WB'(job.x) : WB'(job.y);
         start_w = idx_ff[0] ? cx_w - a_w : cx_w + a_w;
         end_w   = start_w;
         row_w   = idx_ff[1] ? cy_w - b_w : cy_w + b_w;
         vert    = idx_ff[2];
      end else begin
         a_w     = idx_ff[1] ? WB'(job.y) : WB'(job.x);
         b_w     = idx_ff[1] ? WB'(job.x) : WB'(job.y);
         start_w = cx_w - a_w + WB'(1);
         end_w   = cx_w + a_w - WB'(1);
         row_w   = idx_ff[0] ? cy_w - b_w : cy_w + b_w;
         vert    = 1'b0;
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         start_ff <= start_w[CB:0];
         end_ff   <= end_w[CB:0];
         row_ff   <= row_w[CB:0];
         vert_ff  <= vert;
         last_ff  <= is_last;
         done_ff  <= is_last && job.done;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.span_start_x   = start_ff;
   assign rsp.span_end_x     = end_ff;
   assign rsp.row_y          = row_ff;
   assign rsp.vertical_piece = vert_ff;
   assign rsp.last           = last_ff;
   assign rsp.circle_done    = done_ff;

endmodule

>>> bench/circle_span_and_point_generator_core_tb.sv
// ----------------------------------------------------------------------------
// circle_span_and_point_generator_core_tb
// Drives start and advance requests into the circle generator, predicts every
// fill span and outline point per octant step, and checks each response beat
// in order. Covers both draw modes, corner centers and radii, abandoned and
// finished circles, and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module circle_span_and_point_generator_core_tb;
   import csp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB         = COORD_BITS_DEFAULT;
   localparam int DRAIN_WAIT = 24;
   localparam int CYCLE_MAX  = 400000;
   localparam int PHASE_ITEMS = 18;

   typedef struct packed {
      logic signed [CB:0] start_x;
      logic signed [CB:0] end_x;
      logic signed [CB:0] row;
      logic               vert;
      logic               last;
      logic               done;
   } beat_type;

   class circle_scoreboard;
      logic                 mode;
      logic signed [CB-1:0] cen_x;
      logic signed [CB-1:0] cen_y;
      logic        [CB-1:0] pt_x;
      logic        [CB-1:0] pt_y;
      logic signed [CB+3:0] dec;
      bit                   active;
      beat_type             pending_beats[$];
      int                   errors;
      int                   circles;
      int                   steps_fill;
      int                   steps_outline;
      int                   beats_seen;

      function new();
         mode = MODE_FILL;
         cen_x = '0;
         cen_y = '0;
         pt_x = '0;
         pt_y = '0;
         dec = '0;
         active = 0;
         errors = 0;
         circles = 0;
         steps_fill = 0;
         steps_outline = 0;
         beats_seen = 0;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("MISMATCH: %s", msg);
      endtask

      function void push_beat(int s, int e, int row, bit vert, bit last_b, bit fin);
         beat_type b;
         b.start_x = s[CB:0];
         b.end_x   = e[CB:0];
         b.row     = row[CB:0];
         b.vert    = vert;
         b.last    = last_b;
         b.done    = last_b & fin;
         pending_beats.push_back(b);
      endfunction

      // returns number of response beats the item causes
      function int note_item(logic act, logic signed [CB-1:0] ix, logic signed [CB-1:0] iy,
                             logic [CB-2:0] ir);
         int cx, cy, x, y, nx, d;
         bit fin;
         if (act == ACT_START) begin
            cen_x = ix;
            cen_y = iy;
            pt_x = {1'b0, ir};
            pt_y = '0;
            d = D_START - 2 * int'(ir);
            dec = d[CB+3:0];
            active = 1;
            circles++;
            return 0;
         end
         if (!active) return 0;
         cx = cen_x;
         cy = cen_y;
         x = pt_x;
         y = pt_y;
         d = dec;
         nx = x;
         if (d > 0) begin
            d = d + 4 * (y - x) + D_STEP_DIAG;
            nx = x - 1;
         end else begin
            d = d + 4 * y + D_STEP_AXIS;
         end
         fin = (nx < y + 1);
         if (mode == MODE_FILL) begin
            push_beat(cx - x + 1, cx + x - 1, cy + y, 1'b0, 1'b0, fin);
            push_beat(cx - x + 1, cx + x - 1, cy - y, 1'b0, 1'b0, fin);
            push_beat(cx - y + 1, cx + y - 1, cy + x, 1'b0, 1'b0, fin);
            push_beat(cx - y + 1, cx + y - 1, cy - x, 1'b0, 1'b1, fin);
            steps_fill++;
         end else begin
            push_beat(cx + x, cx + x, cy + y, 1'b0, 1'b0, fin);
            push_beat(cx - x, cx - x, cy + y, 1'b0, 1'b0, fin);
            push_beat(cx + x, cx + x, cy - y, 1'b0, 1'b0, fin);
            push_beat(cx - x, cx - x, cy - y, 1'b0, 1'b0, fin);
            push_beat(cx + y, cx + y, cy + x, 1'b1, 1'b0, fin);
            push_beat(cx - y, cx - y, cy + x, 1'b1, 1'b0, fin);
            push_beat(cx + y, cx + y, cy - x, 1'b1, 1'b0, fin);
            push_beat(cx - y, cx - y, cy - x, 1'b1, 1'b1, fin);
            steps_outline++;
         end
         dec = d[CB+3:0];
         pt_x = nx[CB-1:0];
         pt_y = pt_y + CB'(1);
         if (fin) active = 0;
         return (mode == MODE_FILL) ? 4 : 8;
      endfunction

      task check_beat(beat_type got);
         beat_type want;
         beats_seen++;
         if (pending_beats.size() == 0) begin
            report($sformatf("unexpected beat x=%0d..%0d y=%0d", got.start_x, got.end_x,
                             got.row));
            return;
         end
         want = pending_beats.pop_front();
         if (got.start_x !== want.start_x)
            report($sformatf("start_x got %0d want %0d", got.start_x, want.start_x));
         if (got.end_x !== want.end_x)
            report($sformatf("end_x got %0d want %0d", got.end_x, want.end_x));
         if (got.row !== want.row)
            report($sformatf("row_y got %0d want %0d", got.row, want.row));
         if (got.vert !== want.vert)
            report($sformatf("vertical_piece got %b want %b", got.vert, want.vert));
         if (got.last !== want.last)
            report($sformatf("last got %b want %b", got.last, want.last));
         if (got.done !== want.done)
            report($sformatf("circle_done got %b want %b", got.done, want.done));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   csp_req_if #(.CB(CB)) req_ch ();
   csp_rsp_if #(.CB(CB)) rsp_ch ();

   circle_span_and_point_generator_core #(.COORD_BITS(CB)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_ch),
      .rsp_chan      (rsp_ch),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   circle_scoreboard sb = new();
   int send_idle_pct;
   int recv_stall_pct;
   int issued;
   int cycles;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // beat is taken at the next rising edge; values are stable here
   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_beat('{rsp_ch.span_start_x, rsp_ch.span_end_x, rsp_ch.row_y,
                         rsp_ch.vertical_piece, rsp_ch.last, rsp_ch.circle_done});
      end
   end

   task automatic send_item(logic act, logic signed [CB-1:0] ix, logic signed [CB-1:0] iy,
                            logic [CB-2:0] ir);
      int n;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid    <= 1'b0;
         req_ch.action   <= 1'($urandom_range(0, 1));
         req_ch.center_x <= CB'($urandom);
         req_ch.center_y <= CB'($urandom);
         req_ch.radius   <= (CB-1)'($urandom);
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.center_x <= ix;
      req_ch.center_y <= iy;
      req_ch.radius   <= ir;
      forever begin
         @(negedge clock);
         if (req_ch.ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      n = sb.note_item(act, ix, iy, ir);
      if (act == ACT_START || n > 0) issued++;
   endtask

   task automatic send_advance();
      send_item(ACT_ADVANCE, CB'($urandom), CB'($urandom), (CB-1)'($urandom));
   endtask

   // start a circle, then advance until it ends or max_adv steps are taken
   task automatic draw_circle(logic signed [CB-1:0] ix, logic signed [CB-1:0] iy,
                              logic [CB-2:0] ir, int max_adv);
      int k;
      k = 0;
      send_item(ACT_START, ix, iy, ir);
      while (sb.active && k < max_adv) begin
         send_advance();
         k++;
      end
   endtask

   task automatic set_mode(logic m);
      req_ch.valid <= 1'b0;
      while (sb.pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      csr_write_data <= 1'b0;
      sb.mode = m;
   endtask

   task automatic run_random(int quota);
      int goal, sel, r, adv, extra;
      goal = issued + quota;
      while (issued < goal) begin
         sel = $urandom_range(0, 99);
         if (sel < 80) r = $urandom_range(0, 20);
         else if (sel < 95) r = $urandom_range(21, 60);
         else r = $urandom_range(0, (1 << (CB - 1)) - 1);
         if (sel >= 95) adv = $urandom_range(1, 4);
         else if ($urandom_range(0, 99) < 25) adv = $urandom_range(0, 6);
         else adv = 1 << 20;
         draw_circle(CB'($urandom), CB'($urandom), (CB-1)'(r), adv);
         if ($urandom_range(0, 99) < 20) begin
            extra = $urandom_range(1, 2);
            repeat (extra) send_advance();
         end
      end
   endtask

   initial begin
      int idle_s[4];
      int idle_r[4];
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.action  = ACT_START;
      req_ch.center_x = '0;
      req_ch.center_y = '0;
      req_ch.radius  = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      issued         = 0;
      idle_s = '{0, 77, 0, 16};
      idle_r = '{0, 0, 77, 16};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, fill mode from reset
      send_advance();
      draw_circle(16'sd0, 16'sd0, 15'd0, 4);
      send_advance();
      draw_circle(16'sh7fff, -16'sh8000, 15'h7fff, 2);
      draw_circle(-16'sh8000, 16'sh7fff, 15'd5, 8);
      draw_circle(-16'sd1, -16'sd1, 15'd1, 4);

      // directed, outline mode
      set_mode(MODE_OUTLINE);
      draw_circle(-16'sh8000, -16'sh8000, 15'd0, 2);
      draw_circle(-16'sh8000, 16'sh7fff, 15'h7fff, 2);
      draw_circle(16'sd100, -16'sd100, 15'd3, 1);
      draw_circle(16'sh7fff, 16'sh7fff, 15'd4, 8);
      send_advance();

      for (int p = 0; p < 8; p++) begin
         set_mode(p % 2 == 0 ? MODE_FILL : MODE_OUTLINE);
         send_idle_pct  = idle_s[p / 2];
         recv_stall_pct = idle_r[p / 2];
         run_random(PHASE_ITEMS);
      end

      req_ch.valid <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (sb.pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d circles, %0d fill and %0d outline steps, %0d beats checked",
               sb.circles, sb.steps_fill, sb.steps_outline, sb.beats_seen);
      $display("Mismatches: %0d", sb.errors);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
design/csp_pkg.sv
design/csp_if.sv
design/csp_front.sv
design/csp_queue.sv
design/csp_back.sv
design/circle_span_and_point_generator_core.sv
bench/circle_span_and_point_generator_core_tb.sv
